// ----- hdl/keyvalue_beacon_field_extractor_defines.svh -----
// Assertion macros shared by the key=value beacon field extractor.
`ifndef KEYVALUE_BEACON_FIELD_EXTRACTOR_DEFINES_SVH
`define KEYVALUE_BEACON_FIELD_EXTRACTOR_DEFINES_SVH
// Check a consequence in the same cycle as its trigger.
`define KVBFE_CHECK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check a consequence in the cycle after its trigger.
`define KVBFE_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hdl/kvbfe_pkg.sv -----
// Package: beat types, text tables and constants of the beacon field extractor.
package kvbfe_pkg;

	localparam int DEF_UUID_CAPACITY     = 64;
	localparam int DEF_MACHINE_CAPACITY  = 64;
	localparam int DEF_PLATFORM_CAPACITY = 64;
	localparam int DEF_SERVICES_CAPACITY = 64;

	localparam int NUM_FIELDS = 4;
	localparam logic [3:0] PFX_LEN   = 4'd12;
	localparam logic [2:0] UUIDP_LEN = 3'd5;
	localparam logic [3:0] KEY_SAT   = 4'd9;
	localparam logic [6:0] VLEN_SAT  = 7'd127;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_EQ     = 8'h3d;

	// Field codes
	localparam logic [1:0] FLD_UUID     = 2'd0;
	localparam logic [1:0] FLD_MACHINE  = 2'd1;
	localparam logic [1:0] FLD_PLATFORM = 2'd2;
	localparam logic [1:0] FLD_SERVICES = 2'd3;

	typedef enum logic {
		ACT_BYTE = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [1:0]  read_field;
		logic [5:0]  read_index;
	} in_beat_t;

	typedef struct packed {
		logic        packet_done;
		logic        detected;
		logic        excluded;
		logic        malformed;
		logic [7:0]  read_char;
		logic [5:0]  uuid_length;
		logic [5:0]  machine_length;
		logic [5:0]  platform_length;
		logic [5:0]  services_length;
	} out_beat_t;

	// Store access issued by the parser for one beat
	typedef struct packed {
		logic        wr_en;
		logic [1:0]  wr_field;
		logic        wr_bank;
		logic [5:0]  wr_idx;
		logic [7:0]  wr_data;
		logic        rd_en;
		logic [1:0]  rd_field;
		logic        rd_bank;
		logic [5:0]  rd_idx;
	} store_cmd_t;

	// Result of one beat, before the store read data joins it
	typedef struct packed {
		logic             packet_done;
		logic             detected;
		logic             excluded;
		logic             malformed;
		logic             rd_hit;
		logic [1:0]       rd_field;
		logic [3:0][5:0]  lengths;
	} meta_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	function automatic logic [7:0] pfx_char(input logic [3:0] pos);
		logic [7:0] r;
		case (pos)
			4'd0:    r = "t";
			4'd1:    r = "i";
			4'd2:    r = "v";
			4'd3:    r = "o";
			4'd4:    r = "c";
			4'd5:    r = "o";
			4'd6:    r = "n";
			4'd7:    r = "n";
			4'd8:    r = "e";
			4'd9:    r = "c";
			4'd10:   r = "t";
			4'd11:   r = "=";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] uuidp_char(input logic [2:0] pos);
		logic [7:0] r;
		case (pos)
			3'd0:    r = "u";
			3'd1:    r = "u";
			3'd2:    r = "i";
			3'd3:    r = "d";
			3'd4:    r = ":";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] key_text(input logic [1:0] f);
		logic [63:0] r;
		case (f)
			FLD_UUID:     r = "identity";
			FLD_MACHINE:  r = {"machine", 8'h00};
			FLD_PLATFORM: r = "platform";
			FLD_SERVICES: r = "services";
			default:      r = '0;
		endcase
		return r;
	endfunction

	// Character i of key f, first character at i = 0
	function automatic logic [7:0] key_char(input logic [1:0] f, input logic [2:0] i);
		logic [63:0] t;
		t = key_text(f);
		return t[8'(7 - 32'(i)) * 8 +: 8];
	endfunction

	function automatic logic [3:0] key_len(input logic [1:0] f);
		logic [3:0] r;
		case (f)
			FLD_MACHINE: r = 4'd7;
			default:     r = 4'd8;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/kvbfe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kvbfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/kvbfe_parser.sv -----
// Parser: per-beat prefix, key and value tracking, commit logic and store access.
module kvbfe_parser #(
	parameter int UUID_CAPACITY     = kvbfe_pkg::DEF_UUID_CAPACITY,
	parameter int MACHINE_CAPACITY  = kvbfe_pkg::DEF_MACHINE_CAPACITY,
	parameter int PLATFORM_CAPACITY = kvbfe_pkg::DEF_PLATFORM_CAPACITY,
	parameter int SERVICES_CAPACITY = kvbfe_pkg::DEF_SERVICES_CAPACITY
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  kvbfe_pkg::in_beat_t    beat,
	output kvbfe_pkg::store_cmd_t  cmd,
	output kvbfe_pkg::meta_t       meta
);

	// Longest value kept per field
	localparam logic [3:0][6:0] LIMS = {
		7'(SERVICES_CAPACITY - 1), 7'(PLATFORM_CAPACITY - 1),
		7'(MACHINE_CAPACITY - 1), 7'(UUID_CAPACITY - 1)
	};

	logic [3:0]       prefix_pos_q, prefix_pos_d;
	logic             prefix_ok_q, prefix_ok_d;
	logic             seen_eq_q, seen_eq_d;
	logic [3:0]       key_cnt_q, key_cnt_d;
	logic [3:0]       cand_q, cand_d;
	logic [2:0]       upfx_pos_q, upfx_pos_d;
	logic             upfx_ok_q, upfx_ok_d;
	logic [6:0]       vlen_q, vlen_d;
	logic             malformed_q, malformed_d;
	logic             nul_seen_q, nul_seen_d;
	logic [3:0]       bank_q, bank_d;
	logic [3:0][5:0]  len_q, len_d;

	logic [1:0]       fsel;
	logic [6:0]       lim_sel;
	logic [7:0]       lb;
	logic             det;

	// Pick the first surviving key candidate
	always_comb begin
		fsel = kvbfe_pkg::FLD_UUID;
		if (cand_q[0]) begin
			fsel = kvbfe_pkg::FLD_UUID;
		end else if (cand_q[1]) begin
			fsel = kvbfe_pkg::FLD_MACHINE;
		end else if (cand_q[2]) begin
			fsel = kvbfe_pkg::FLD_PLATFORM;
		end else begin
			fsel = kvbfe_pkg::FLD_SERVICES;
		end
		lim_sel = LIMS[fsel];
	end

	assign lb = kvbfe_pkg::to_lower(beat.data_byte);

	// Next state, store access and result for one beat
	always_comb begin
		prefix_pos_d = prefix_pos_q;
		prefix_ok_d  = prefix_ok_q;
		seen_eq_d    = seen_eq_q;
		key_cnt_d    = key_cnt_q;
		cand_d       = cand_q;
		upfx_pos_d   = upfx_pos_q;
		upfx_ok_d    = upfx_ok_q;
		vlen_d       = vlen_q;
		malformed_d  = malformed_q;
		nul_seen_d   = nul_seen_q;
		bank_d       = bank_q;
		len_d        = len_q;
		cmd          = '0;
		meta         = '0;
		det          = 1'b0;

		if (accept && beat.action == kvbfe_pkg::ACT_READ) begin
			// Read one committed character from the active bank
			cmd.rd_en    = 1'b1;
			cmd.rd_field = beat.read_field;
			cmd.rd_bank  = bank_q[beat.read_field];
			cmd.rd_idx   = beat.read_index;
			meta.rd_hit  = beat.read_index < len_q[beat.read_field];
			meta.rd_field = beat.read_field;
		end else if (accept) begin
			if (prefix_ok_q) begin
				// Match the packet prefix
				if (prefix_pos_q < kvbfe_pkg::PFX_LEN) begin
					if (lb != kvbfe_pkg::pfx_char(prefix_pos_q)) begin
						prefix_ok_d = 1'b0;
					end else begin
						prefix_pos_d = prefix_pos_q + 4'd1;
					end
				end
				if (prefix_ok_d) begin
					if (beat.data_byte == kvbfe_pkg::CH_LF) begin
						// End of line: flag a line without '=', commit a matched value, then clear the line
						if (!seen_eq_q) begin
							malformed_d = 1'b1;
						end else if (cand_q != 4'd0 && prefix_pos_d == kvbfe_pkg::PFX_LEN &&
								(fsel != kvbfe_pkg::FLD_UUID ||
								(upfx_ok_q && upfx_pos_q == kvbfe_pkg::UUIDP_LEN))) begin
							len_d[fsel]  = (vlen_q < lim_sel) ? vlen_q[5:0] : lim_sel[5:0];
							bank_d[fsel] = ~bank_q[fsel];
						end
						seen_eq_d  = 1'b0;
						key_cnt_d  = 4'd0;
						cand_d     = 4'hf;
						upfx_pos_d = 3'd0;
						upfx_ok_d  = 1'b1;
						vlen_d     = 7'd0;
						nul_seen_d = 1'b0;
					end else if (!seen_eq_q) begin
						if (beat.data_byte == kvbfe_pkg::CH_EQ) begin
							// Key ends: keep candidates of exact length
							seen_eq_d = 1'b1;
							for (int f = 0; f < kvbfe_pkg::NUM_FIELDS; f++) begin
								cand_d[f] = cand_q[f] &&
									(kvbfe_pkg::key_len(2'(f)) == key_cnt_q);
							end
						end else begin
							// Key character: drop candidates that differ
							for (int f = 0; f < kvbfe_pkg::NUM_FIELDS; f++) begin
								if (key_cnt_q >= kvbfe_pkg::key_len(2'(f)) || key_cnt_q[3] ||
										lb != kvbfe_pkg::key_char(2'(f), key_cnt_q[2:0])) begin
									cand_d[f] = 1'b0;
								end
							end
							if (key_cnt_q < kvbfe_pkg::KEY_SAT) begin
								key_cnt_d = key_cnt_q + 4'd1;
							end
						end
					end else if (cand_q != 4'd0) begin
						if (fsel == kvbfe_pkg::FLD_UUID && upfx_pos_q < kvbfe_pkg::UUIDP_LEN) begin
							// Check and strip the identity value prefix
							if (lb != kvbfe_pkg::uuidp_char(upfx_pos_q)) begin
								upfx_ok_d = 1'b0;
							end
							upfx_pos_d = upfx_pos_q + 3'd1;
						end else begin
							// Value character into the inactive bank
							if (vlen_q < lim_sel) begin
								cmd.wr_en    = 1'b1;
								cmd.wr_field = fsel;
								cmd.wr_bank  = ~bank_q[fsel];
								cmd.wr_idx   = vlen_q[5:0];
								cmd.wr_data  = nul_seen_q ? 8'h00 : beat.data_byte;
								if (beat.data_byte == 8'h00) begin
									nul_seen_d = 1'b1;
								end
							end
							if (vlen_q < kvbfe_pkg::VLEN_SAT) begin
								vlen_d = vlen_q + 7'd1;
							end
						end
					end
				end
			end
			if (beat.last_byte) begin
				// Close the packet and report its status
				det = prefix_ok_d && prefix_pos_d == kvbfe_pkg::PFX_LEN;
				meta.packet_done = 1'b1;
				meta.detected    = det;
				meta.excluded    = !det;
				meta.malformed   = det && (malformed_d || beat.data_byte != kvbfe_pkg::CH_LF);
				prefix_pos_d = 4'd0;
				prefix_ok_d  = 1'b1;
				malformed_d  = 1'b0;
				seen_eq_d    = 1'b0;
				key_cnt_d    = 4'd0;
				cand_d       = 4'hf;
				upfx_pos_d   = 3'd0;
				upfx_ok_d    = 1'b1;
				vlen_d       = 7'd0;
				nul_seen_d   = 1'b0;
			end
		end
		meta.lengths = len_d;
	end

	// Hold parser state between beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_pos_q <= 4'd0;
			prefix_ok_q  <= 1'b1;
			seen_eq_q    <= 1'b0;
			key_cnt_q    <= 4'd0;
			cand_q       <= 4'hf;
			upfx_pos_q   <= 3'd0;
			upfx_ok_q    <= 1'b1;
			vlen_q       <= 7'd0;
			malformed_q  <= 1'b0;
			nul_seen_q   <= 1'b0;
			bank_q       <= 4'd0;
			len_q        <= '0;
		end else if (accept) begin
			prefix_pos_q <= prefix_pos_d;
			prefix_ok_q  <= prefix_ok_d;
			seen_eq_q    <= seen_eq_d;
			key_cnt_q    <= key_cnt_d;
			cand_q       <= cand_d;
			upfx_pos_q   <= upfx_pos_d;
			upfx_ok_q    <= upfx_ok_d;
			vlen_q       <= vlen_d;
			malformed_q  <= malformed_d;
			nul_seen_q   <= nul_seen_d;
			bank_q       <= bank_d;
			len_q        <= len_d;
		end
	end

endmodule

// ----- hdl/keyvalue_beacon_field_extractor.sv -----
// Top level: parser, field stores and the two-deep result pipeline.
//
//  channel | signals                     | direction | beat type
//  --------+-----------------------------+-----------+------------
//  in      | in_valid, in_ready, in_data | sink      | in_beat_t
//  out     | out_valid, out_ready,       | source    | out_beat_t
//          | out_data                    |           |
//
// One beat is accepted per cycle while in_ready is high; each result passes through
// the registered read of the field stores and then the output register.
// Reset clears all parser state, bank selects and committed lengths at once; the
// stores are not cleared, since read data is used only at committed positions.
// A stalled output holds up to two results (stage 1 and output register) while
// input stays ready until both are full.
`include "keyvalue_beacon_field_extractor_defines.svh"

module keyvalue_beacon_field_extractor #(
	parameter int UUID_CAPACITY     = kvbfe_pkg::DEF_UUID_CAPACITY,
	parameter int MACHINE_CAPACITY  = kvbfe_pkg::DEF_MACHINE_CAPACITY,
	parameter int PLATFORM_CAPACITY = kvbfe_pkg::DEF_PLATFORM_CAPACITY,
	parameter int SERVICES_CAPACITY = kvbfe_pkg::DEF_SERVICES_CAPACITY
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  kvbfe_pkg::in_beat_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output kvbfe_pkg::out_beat_t  out_data
);

	logic                   accept;
	logic                   s1_adv;
	kvbfe_pkg::store_cmd_t  cmd;
	kvbfe_pkg::meta_t       meta;
	logic                   valid_s1;
	kvbfe_pkg::meta_t       meta_s1;
	logic [3:0][7:0]        rdata;
	logic                   valid_s2;
	kvbfe_pkg::out_beat_t   beat_s2;
	kvbfe_pkg::out_beat_t   beat_s1;

	// Advance stage 1 when the output register is free or drains
	assign s1_adv   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || s1_adv;
	assign accept   = in_valid && in_ready;

	kvbfe_parser #(
		.UUID_CAPACITY     (UUID_CAPACITY),
		.MACHINE_CAPACITY  (MACHINE_CAPACITY),
		.PLATFORM_CAPACITY (PLATFORM_CAPACITY),
		.SERVICES_CAPACITY (SERVICES_CAPACITY)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.beat   (in_data),
		.cmd    (cmd),
		.meta   (meta)
	);

	// Two banks per field, each sized to the field capacity rounded up to a power of two
	for (genvar g = 0; g < kvbfe_pkg::NUM_FIELDS; g++) begin : g_store
		localparam int CAP = (g == 0) ? UUID_CAPACITY :
			(g == 1) ? MACHINE_CAPACITY :
			(g == 2) ? PLATFORM_CAPACITY : SERVICES_CAPACITY;
		localparam int AW = (CAP > 1) ? $clog2(CAP) : 1;

		kvbfe_ram #(
			.WIDTH (8),
			.DEPTH (2 ** (AW + 1))
		) u_ram (
			.clk   (clk),
			.we    (cmd.wr_en && cmd.wr_field == 2'(g)),
			.waddr ({cmd.wr_bank, cmd.wr_idx[AW-1:0]}),
			.wdata (cmd.wr_data),
			.re    (cmd.rd_en && cmd.rd_field == 2'(g)),
			.raddr ({cmd.rd_bank, cmd.rd_idx[AW-1:0]}),
			.rdata (rdata[g])
		);
	end

	// Stage 1: hold the beat result alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
	end

	// Assemble the result beat
	always_comb begin
		beat_s1                 = '0;
		beat_s1.packet_done     = meta_s1.packet_done;
		beat_s1.detected        = meta_s1.detected;
		beat_s1.excluded        = meta_s1.excluded;
		beat_s1.malformed       = meta_s1.malformed;
		beat_s1.read_char       = meta_s1.rd_hit ? rdata[meta_s1.rd_field] : 8'h00;
		beat_s1.uuid_length     = meta_s1.lengths[kvbfe_pkg::FLD_UUID];
		beat_s1.machine_length  = meta_s1.lengths[kvbfe_pkg::FLD_MACHINE];
		beat_s1.platform_length = meta_s1.lengths[kvbfe_pkg::FLD_PLATFORM];
		beat_s1.services_length = meta_s1.lengths[kvbfe_pkg::FLD_SERVICES];
	end

	// Stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			beat_s2 <= beat_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = beat_s2;

	// Checks
	`KVBFE_CHECK_NOW(a_done_flags, valid_s2 && beat_s2.packet_done, beat_s2.detected != beat_s2.excluded, "packet status must be exactly one of detected or excluded")
	`KVBFE_CHECK_NOW(a_flags_need_done, valid_s2 && !beat_s2.packet_done, !beat_s2.detected && !beat_s2.excluded && !beat_s2.malformed, "status flags without packet close")
	`KVBFE_CHECK_NOW(a_malformed_detected, valid_s2 && beat_s2.malformed, beat_s2.detected, "malformed reported on an undetected packet")
	`KVBFE_CHECK_NEXT(a_s1_hold, valid_s1 && !s1_adv, valid_s1 && $stable(meta_s1), "stalled stage 1 result lost or changed")

endmodule
